>>> rtl/core/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types, constants and helpers for the line segment clipper.
// ----------------------------------------------------------------------------
`default_nettype none

package lsc_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DW          = COORD_WIDTH + 1;   // difference / magnitude width
    localparam int PW          = 2 * DW;            // product / quotient width
    localparam int DIV_SPS     = 2;                 // quotient bits per divider stage
    localparam int DIV_STG     = PW / DIV_SPS;
    localparam int PASS_STG    = DIV_STG + 3;       // decide, multiply, divide, apply
    localparam int CLIP_PASSES = 8;

    localparam logic [3:0] CODE_LEFT  = 4'd1;
    localparam logic [3:0] CODE_RIGHT = 4'd2;
    localparam logic [3:0] CODE_BELOW = 4'd4;
    localparam logic [3:0] CODE_ABOVE = 4'd8;

    typedef enum logic [1:0] {
        REG_LEFT   = 2'd0,
        REG_BOTTOM = 2'd1,
        REG_RIGHT  = 2'd2,
        REG_TOP    = 2'd3
    } reg_idx_t;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DW-1:0]          diff_t;

    typedef struct packed {
        logic   valid;
        logic   done;       // accept/reject already decided
        logic   acc;
        coord_t x1;
        coord_t y1;
        coord_t x2;
        coord_t y2;
    } item_t;

    typedef struct packed {
        logic   act;        // a move is in progress in this pass
        logic   mv_p1;      // move first endpoint
        logic   calc_y;     // computed coordinate is y (fixed one is x)
        logic   neg;
        logic   zdiv;
        coord_t fixv;
        coord_t base;
    } op_t;

    typedef struct packed {
        item_t          it;
        op_t            op;
        logic [DW-1:0]  ma;
        logic [DW-1:0]  mb;
        logic [DW-1:0]  md;
        logic [DW-1:0]  rem;
        logic [PW-1:0]  num;
        logic [PW-1:0]  quo;
    } stg_t;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [PW-1:0] num;
        logic [PW-1:0] quo;
    } div_t;

    function automatic logic [3:0] region(coord_t x, coord_t y, coord_t xl,
                                          coord_t yb, coord_t xr, coord_t yt);
        logic [3:0] c;
        c = '0;
        if (x < xl)
            c = c | CODE_LEFT;
        else if (x > xr)
            c = c | CODE_RIGHT;
        if (y < yb)
            c = c | CODE_BELOW;
        else if (y > yt)
            c = c | CODE_ABOVE;
        return c;
    endfunction

    function automatic diff_t sub_ext(coord_t a, coord_t b);
        return diff_t'(a) - diff_t'(b);
    endfunction

    function automatic logic [DW-1:0] mag(diff_t v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    // one restoring division step
    function automatic div_t div_step(div_t s, logic [DW-1:0] d);
        logic [DW:0] r2;
        div_t        o;
        r2 = {s.rem, s.num[PW-1]};
        o.num = {s.num[PW-2:0], 1'b0};
        if (r2 >= {1'b0, d}) begin
            r2    = r2 - {1'b0, d};
            o.quo = {s.quo[PW-2:0], 1'b1};
        end else begin
            o.quo = {s.quo[PW-2:0], 1'b0};
        end
        o.rem = r2[DW-1:0];
        return o;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/line_segment_clipper.sv
// ----------------------------------------------------------------------------
// line_segment_clipper
// Cohen-Sutherland clipping of one segment per cycle against a window.
// ----------------------------------------------------------------------------
// A segment is taken on any cycle with start high (busy is always low) and done
// rises once it has left the last clip pass and the final check register; one
// result per cycle at full rate. Each of the eight clip passes is a stage
// train: region decide, a 17x17 multiply, a restoring divider giving two
// quotient bits per stage (17 stages), and the boundary update; a last stage
// decides accept or reject. The receiver cannot stall: each result
// is on the ports for the single cycle that done is high. Rejected segments
// report zero coordinates. Window registers are written through the cfg
// channel (always ready) and must only change while no segment is in flight,
// since the decide stages and the final check read them live.
`default_nettype none

module line_segment_clipper
    import lsc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic signed [COORD_WIDTH-1:0] start_x,
    input  wire logic signed [COORD_WIDTH-1:0] start_y,
    input  wire logic signed [COORD_WIDTH-1:0] end_x,
    input  wire logic signed [COORD_WIDTH-1:0] end_y,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [1:0]              cfg_index,
    input  wire logic [COORD_WIDTH-1:0]  cfg_data,
    output logic                         done,
    output logic                         accepted,
    output logic signed [COORD_WIDTH-1:0] clip_start_x,
    output logic signed [COORD_WIDTH-1:0] clip_start_y,
    output logic signed [COORD_WIDTH-1:0] clip_end_x,
    output logic signed [COORD_WIDTH-1:0] clip_end_y
);

    // window registers
    coord_t win_left_reg, win_bottom_reg, win_right_reg, win_top_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg   <= COORD_WIDTH'(10);
            win_bottom_reg <= COORD_WIDTH'(10);
            win_right_reg  <= COORD_WIDTH'(50);
            win_top_reg    <= COORD_WIDTH'(50);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_LEFT:   win_left_reg   <= cfg_data;
                REG_BOTTOM: win_bottom_reg <= cfg_data;
                REG_RIGHT:  win_right_reg  <= cfg_data;
                REG_TOP:    win_top_reg    <= cfg_data;
                default:    ;
            endcase
        end
    end

    // pass_in[p]: item entering pass p; pass_in[CLIP_PASSES] goes to the final check
    item_t pass_in [CLIP_PASSES+1];
    stg_t  st_reg  [CLIP_PASSES][PASS_STG];

    always_comb
    begin
        pass_in[0].valid = start && !busy;
        pass_in[0].done  = 1'b0;
        pass_in[0].acc   = 1'b0;
        pass_in[0].x1    = start_x;
        pass_in[0].y1    = start_y;
        pass_in[0].x2    = end_x;
        pass_in[0].y2    = end_y;
    end

    genvar p, k;
    generate
        for (p = 0; p < CLIP_PASSES; p++)
        begin : g_pass
            stg_t dec_next, mul_next, app_next;

            // region decide and operand setup
            always_comb
            begin
                item_t      it;
                logic [3:0] c1, c2, c;
                diff_t      da, db, dd;
                it = pass_in[p];
                c1 = region(it.x1, it.y1, win_left_reg, win_bottom_reg,
                            win_right_reg, win_top_reg);
                c2 = region(it.x2, it.y2, win_left_reg, win_bottom_reg,
                            win_right_reg, win_top_reg);
                c  = (c1 != 4'd0) ? c1 : c2;
                dec_next = '0;
                dec_next.it = it;
                da = '0;
                db = '0;
                dd = '0;
                if (!it.done)
                begin
                    if (c1 == 4'd0 && c2 == 4'd0)
                    begin
                        dec_next.it.done = 1'b1;
                        dec_next.it.acc  = 1'b1;
                    end
                    else if ((c1 & c2) != 4'd0)
                    begin
                        dec_next.it.done = 1'b1;
                    end
                    else
                    begin
                        dec_next.op.act   = 1'b1;
                        dec_next.op.mv_p1 = (c1 != 4'd0);
                        priority if ((c & CODE_ABOVE) != 4'd0)
                        begin
                            da = sub_ext(it.x2, it.x1);
                            db = sub_ext(win_top_reg, it.y1);
                            dd = sub_ext(it.y2, it.y1);
                            dec_next.op.base   = it.x1;
                            dec_next.op.fixv   = win_top_reg;
                            dec_next.op.calc_y = 1'b0;
                        end
                        else if ((c & CODE_BELOW) != 4'd0)
                        begin
                            da = sub_ext(it.x2, it.x1);
                            db = sub_ext(win_bottom_reg, it.y1);
                            dd = sub_ext(it.y2, it.y1);
                            dec_next.op.base   = it.x1;
                            dec_next.op.fixv   = win_bottom_reg;
                            dec_next.op.calc_y = 1'b0;
                        end
                        else if ((c & CODE_RIGHT) != 4'd0)
                        begin
                            da = sub_ext(it.y2, it.y1);
                            db = sub_ext(win_right_reg, it.x1);
                            dd = sub_ext(it.x2, it.x1);
                            dec_next.op.base   = it.y1;
                            dec_next.op.fixv   = win_right_reg;
                            dec_next.op.calc_y = 1'b1;
                        end
                        else
                        begin
                            da = sub_ext(it.y2, it.y1);
                            db = sub_ext(win_left_reg, it.x1);
                            dd = sub_ext(it.x2, it.x1);
                            dec_next.op.base   = it.y1;
                            dec_next.op.fixv   = win_left_reg;
                            dec_next.op.calc_y = 1'b1;
                        end
                    end
                end
                dec_next.op.neg  = da[DW-1] ^ db[DW-1] ^ dd[DW-1];
                dec_next.op.zdiv = (dd == '0);
                dec_next.ma = mag(da);
                dec_next.mb = mag(db);
                dec_next.md = mag(dd);
            end

            // product of magnitudes, divider seeded
            always_comb
            begin
                mul_next     = st_reg[p][0];
                mul_next.num = PW'(st_reg[p][0].ma) * PW'(st_reg[p][0].mb);
                mul_next.rem = '0;
                mul_next.quo = '0;
            end

            // boundary update; quotient wraps to the coordinate width
            always_comb
            begin
                stg_t   s;
                coord_t q, nc;
                s  = st_reg[p][PASS_STG-2];
                q  = s.op.zdiv ? '0 : s.quo[COORD_WIDTH-1:0];
                nc = s.op.neg ? (s.op.base - q) : (s.op.base + q);
                app_next = s;
                if (s.op.act)
                begin
                    if (s.op.mv_p1)
                    begin
                        app_next.it.x1 = s.op.calc_y ? s.op.fixv : nc;
                        app_next.it.y1 = s.op.calc_y ? nc : s.op.fixv;
                    end
                    else
                    begin
                        app_next.it.x2 = s.op.calc_y ? s.op.fixv : nc;
                        app_next.it.y2 = s.op.calc_y ? nc : s.op.fixv;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    st_reg[p][0].it.valid          <= 1'b0;
                    st_reg[p][1].it.valid          <= 1'b0;
                    st_reg[p][PASS_STG-1].it.valid <= 1'b0;
                end
                else
                begin
                    st_reg[p][0]          <= dec_next;
                    st_reg[p][1]          <= mul_next;
                    st_reg[p][PASS_STG-1] <= app_next;
                end
            end

            for (k = 0; k < DIV_STG; k++)
            begin : g_div
                stg_t div_next;

                always_comb
                begin
                    div_t d;
                    d.rem = st_reg[p][k+1].rem;
                    d.num = st_reg[p][k+1].num;
                    d.quo = st_reg[p][k+1].quo;
                    for (int j = 0; j < DIV_SPS; j++)
                        d = div_step(d, st_reg[p][k+1].md);
                    div_next     = st_reg[p][k+1];
                    div_next.rem = d.rem;
                    div_next.num = d.num;
                    div_next.quo = d.quo;
                end

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        st_reg[p][k+2].it.valid <= 1'b0;
                    else
                        st_reg[p][k+2] <= div_next;
                end
            end

            assign pass_in[p+1] = st_reg[p][PASS_STG-1].it;
        end
    endgenerate

    // final accept/reject check after the last pass
    logic   done_reg, accepted_reg;
    coord_t csx_reg, csy_reg, cex_reg, cey_reg;
    logic   fin_acc;
    item_t  fin_it;

    always_comb
    begin
        logic [3:0] c1, c2;
        fin_it = pass_in[CLIP_PASSES];
        c1 = region(fin_it.x1, fin_it.y1, win_left_reg, win_bottom_reg,
                    win_right_reg, win_top_reg);
        c2 = region(fin_it.x2, fin_it.y2, win_left_reg, win_bottom_reg,
                    win_right_reg, win_top_reg);
        fin_acc = fin_it.done ? fin_it.acc : (c1 == 4'd0 && c2 == 4'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= fin_it.valid;
    end

    always_ff @(posedge clk)
    begin
        accepted_reg <= fin_acc;
        csx_reg      <= fin_acc ? fin_it.x1 : '0;
        csy_reg      <= fin_acc ? fin_it.y1 : '0;
        cex_reg      <= fin_acc ? fin_it.x2 : '0;
        cey_reg      <= fin_acc ? fin_it.y2 : '0;
    end

    assign done         = done_reg;
    assign accepted     = accepted_reg;
    assign clip_start_x = csx_reg;
    assign clip_start_y = csy_reg;
    assign clip_end_x   = cex_reg;
    assign clip_end_y   = cey_reg;

    // an accepted segment lies inside the window (window held while in flight)
    a_inside_x: assert property (@(posedge clk) disable iff (!rst_n)
        (done && accepted) |-> (clip_start_x >= win_left_reg && clip_start_x <= win_right_reg
                                && clip_end_x >= win_left_reg && clip_end_x <= win_right_reg))
        else $error("accepted segment x outside window");

    a_inside_y: assert property (@(posedge clk) disable iff (!rst_n)
        (done && accepted) |-> (clip_start_y >= win_bottom_reg && clip_start_y <= win_top_reg
                                && clip_end_y >= win_bottom_reg && clip_end_y <= win_top_reg))
        else $error("accepted segment y outside window");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !accepted) |-> (clip_start_x == '0 && clip_start_y == '0
                                 && clip_end_x == '0 && clip_end_y == '0))
        else $error("rejected segment with nonzero coordinates");

    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> st_reg[0][0].it.valid)
        else $error("accepted segment lost at pipeline entry");

endmodule

`default_nettype wire

>>> tb/tb_line_segment_clipper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_segment_clipper
// Self-checking bench for the Cohen-Sutherland segment clipper: segments are
// pushed through a command port with random gaps, every result strobe is
// compared against an in-bench clipping predictor, across several windows.
// ----------------------------------------------------------------------------
module tb_line_segment_clipper
    import lsc_pkg::*;
();

    localparam int WATCHDOG_CYCLES = 3000;
    localparam int DRAIN_CYCLES    = 200;   // pipeline is 161 deep

    typedef struct {
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
    } segment_t;

    typedef struct {
        logic   acc;
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
    } clip_t;

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    coord_t start_x, start_y, end_x, end_y;
    logic   cfg_valid;
    logic   cfg_ready;
    logic [1:0]             cfg_index;
    logic [COORD_WIDTH-1:0] cfg_data;
    logic   done;
    logic   accepted;
    coord_t clip_start_x, clip_start_y, clip_end_x, clip_end_y;

    segment_t seg_queue[$];     // segments waiting for the driver
    clip_t    clip_queue[$];    // predicted results, oldest first

    // shadow of the window registers, updated on each cfg transfer
    coord_t win_left, win_bottom, win_right, win_top;

    logic took_seg;     // a segment transfer happened at the last rising edge
    int   gap_left;
    bit   no_idle;      // burst mode for the current phase
    int   error_count;
    int   quiet_cycles;

    line_segment_clipper DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .accepted     (accepted),
        .clip_start_x (clip_start_x),
        .clip_start_y (clip_start_y),
        .clip_end_x   (clip_end_x),
        .clip_end_y   (clip_end_y)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [3:0] outcode(longint x, longint y);
        logic [3:0] c;
        c = '0;
        if (x < win_left)
            c |= CODE_LEFT;
        else if (x > win_right)
            c |= CODE_RIGHT;
        if (y < win_bottom)
            c |= CODE_BELOW;
        else if (y > win_top)
            c |= CODE_ABOVE;
        return c;
    endfunction

    // base + da*db/dd, truncating toward zero, wrapped to coordinate width
    function automatic longint edge_point(longint base, longint da, longint db,
                                          longint dd);
        longint q;
        coord_t w;
        q = 0;
        if (dd != 0) begin
            q = ((da < 0 ? -da : da) * (db < 0 ? -db : db)) / (dd < 0 ? -dd : dd);
            if (((da < 0) != (db < 0)) != (dd < 0))
                q = -q;
        end
        w = coord_t'(base + q);
        return longint'(w);
    endfunction

    function automatic clip_t clip_segment(segment_t s);
        clip_t      r;
        longint     x1, y1, x2, y2, nx, ny;
        logic [3:0] c1, c2, c;
        bit         ok;
        x1 = s.sx;
        y1 = s.sy;
        x2 = s.ex;
        y2 = s.ey;
        ok = 0;
        for (int pass = 0; pass <= CLIP_PASSES; pass++) begin
            c1 = outcode(x1, y1);
            c2 = outcode(x2, y2);
            if (c1 == 0 && c2 == 0) begin
                ok = 1;
                break;
            end
            if ((c1 & c2) != 0 || pass == CLIP_PASSES)
                break;
            c = (c1 != 0) ? c1 : c2;
            if (c & CODE_ABOVE) begin
                nx = edge_point(x1, x2 - x1, longint'(win_top) - y1, y2 - y1);
                ny = win_top;
            end else if (c & CODE_BELOW) begin
                nx = edge_point(x1, x2 - x1, longint'(win_bottom) - y1, y2 - y1);
                ny = win_bottom;
            end else if (c & CODE_RIGHT) begin
                ny = edge_point(y1, y2 - y1, longint'(win_right) - x1, x2 - x1);
                nx = win_right;
            end else begin
                ny = edge_point(y1, y2 - y1, longint'(win_left) - x1, x2 - x1);
                nx = win_left;
            end
            if (c1 != 0) begin
                x1 = nx;
                y1 = ny;
            end else begin
                x2 = nx;
                y2 = ny;
            end
        end
        r.acc = ok;
        r.sx  = ok ? coord_t'(x1) : '0;
        r.sy  = ok ? coord_t'(y1) : '0;
        r.ex  = ok ? coord_t'(x2) : '0;
        r.ey  = ok ? coord_t'(y2) : '0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: one segment per transfer, random gaps unless in burst mode
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 70)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start    <= 1'b0;
            start_x  <= '0;
            start_y  <= '0;
            end_x    <= '0;
            end_y    <= '0;
            gap_left <= 0;
        end else if (!start || took_seg) begin
            if (gap_left > 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (seg_queue.size() > 0) begin
                segment_t s;
                s = seg_queue.pop_front();
                start    <= 1'b1;
                start_x  <= s.sx;
                start_y  <= s.sy;
                end_x    <= s.ex;
                end_y    <= s.ey;
                gap_left <= pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on each segment transfer, checks each result strobe
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic seg_now;
        logic any_xfer;
        seg_now  = 1'b0;
        any_xfer = 1'b0;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                any_xfer = 1'b1;
                case (reg_idx_t'(cfg_index))
                    REG_LEFT:   win_left   = coord_t'(cfg_data);
                    REG_BOTTOM: win_bottom = coord_t'(cfg_data);
                    REG_RIGHT:  win_right  = coord_t'(cfg_data);
                    REG_TOP:    win_top    = coord_t'(cfg_data);
                endcase
            end
            if (start && !busy) begin
                segment_t s;
                seg_now  = 1'b1;
                any_xfer = 1'b1;
                s.sx = start_x;
                s.sy = start_y;
                s.ex = end_x;
                s.ey = end_y;
                clip_queue.push_back(clip_segment(s));
            end
            if (done) begin
                any_xfer = 1'b1;
                if (clip_queue.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result: acc=%0b (%0d,%0d)-(%0d,%0d)",
                                 accepted, clip_start_x, clip_start_y,
                                 clip_end_x, clip_end_y);
                end else begin
                    clip_t e;
                    e = clip_queue.pop_front();
                    if (accepted !== e.acc || clip_start_x !== e.sx ||
                        clip_start_y !== e.sy || clip_end_x !== e.ex ||
                        clip_end_y !== e.ey) begin
                        error_count++;
                        if (error_count <= 10)
                            $display({"mismatch: exp acc=%0b (%0d,%0d)-(%0d,%0d)",
                                      " got acc=%0b (%0d,%0d)-(%0d,%0d)"},
                                     e.acc, e.sx, e.sy, e.ex, e.ey, accepted,
                                     clip_start_x, clip_start_y, clip_end_x,
                                     clip_end_y);
                    end
                end
            end
            quiet_cycles <= any_xfer ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_CYCLES);
                $display("tb_line_segment_clipper: done, errors");
                $finish;
            end
        end
        took_seg <= seg_now;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_seg(int sx, int sy, int ex, int ey);
        segment_t s;
        s.sx = coord_t'(sx);
        s.sy = coord_t'(sy);
        s.ex = coord_t'(ex);
        s.ey = coord_t'(ey);
        seg_queue.push_back(s);
    endtask

    task automatic write_reg(reg_idx_t idx, int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= COORD_WIDTH'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_window(int l, int b, int r, int t);
        write_reg(REG_LEFT, l);
        write_reg(REG_BOTTOM, b);
        write_reg(REG_RIGHT, r);
        write_reg(REG_TOP, t);
    endtask

    // drains the pipeline: pauses stimulus until every result is back
    task automatic wait_idle();
        wait (seg_queue.size() == 0 && !start);
        wait (clip_queue.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // a coordinate near a window span, or anywhere
    function automatic int near(coord_t a, coord_t b);
        int lo, hi;
        if ($urandom_range(0, 4) == 0)
            return int'($urandom_range(0, 65535));
        lo = (a < b ? int'(a) : int'(b)) - 64;
        hi = (a < b ? int'(b) : int'(a)) + 64;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    task automatic random_segs(int n);
        for (int i = 0; i < n; i++)
            add_seg(near(win_left, win_right), near(win_bottom, win_top),
                    near(win_left, win_right), near(win_bottom, win_top));
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        no_idle      = 0;
        error_count  = 0;
        quiet_cycles = 0;
        took_seg     = 1'b0;
        win_left     = 10;
        win_bottom   = 10;
        win_right    = 50;
        win_top      = 50;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset window 10..50: trivial accept, trivial rejects, each edge crossing
        add_seg(20, 20, 40, 40);
        add_seg(0, 0, 5, 60);
        add_seg(60, 0, 70, 60);
        add_seg(0, 0, 60, 5);
        add_seg(0, 60, 60, 70);
        add_seg(30, 30, 30, 80);
        add_seg(30, 30, 30, -5);
        add_seg(30, 30, 90, 30);
        add_seg(30, 30, -9, 30);
        add_seg(0, 30, 60, 35);
        add_seg(5, 0, 70, 80);
        add_seg(0, 45, 15, 60);
        add_seg(-32768, -32768, 32767, 32767);
        add_seg(32767, -32768, -32768, 32767);
        add_seg(-32768, 30, 32767, 30);
        add_seg(10, 10, 50, 50);
        add_seg(-1, -1, -1, -1);
        add_seg(32767, 32767, 32767, 32767);
        wait_idle();

        // full-range window, then point window, then inverted (wrapping) windows
        set_window(-32768, -32768, 32767, 32767);
        add_seg(-32768, -32768, 32767, 32767);
        random_segs(40);
        wait_idle();
        set_window(0, 0, 0, 0);
        add_seg(-5, -5, 5, 5);
        random_segs(40);
        wait_idle();
        set_window(32767, 32767, -32768, -32768);
        random_segs(30);
        wait_idle();
        set_window(50, 40, -20, -30);
        random_segs(40);
        wait_idle();

        for (int ph = 0; ph < 7; ph++) begin
            int l, b, r, t;
            l = int'(coord_t'($urandom_range(0, 65535)));
            b = int'(coord_t'($urandom_range(0, 65535)));
            r = int'(coord_t'($urandom_range(0, 65535)));
            t = int'(coord_t'($urandom_range(0, 65535)));
            if (ph % 3 != 2) begin
                // mostly sane windows; some narrow ones
                if (r < l) begin
                    int x;
                    x = l; l = r; r = x;
                end
                if (t < b) begin
                    int x;
                    x = b; b = t; t = x;
                end
                if (ph == 1) begin
                    r = l + int'($urandom_range(0, 200));
                    t = b + int'($urandom_range(0, 200));
                end
            end
            no_idle = (ph == 3);
            set_window(l, b, r, t);
            random_segs(65);
            wait_idle();
        end

        wait_idle();
        if (error_count == 0)
            $display("tb_line_segment_clipper: done, clean");
        else
            $display("tb_line_segment_clipper: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/lsc_pkg.sv
rtl/core/line_segment_clipper.sv
tb/tb_line_segment_clipper.sv
